### rtl/core/circular_lbp_code_assert.svh
// Assertion macros shared by the circular LBP RTL files.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef CIRCULAR_LBP_CODE_ASSERT_SVH
`define CIRCULAR_LBP_CODE_ASSERT_SVH
`ifndef SYNTHESIS
`define CLBP_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("clbp assertion failed");
`define CLBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clbp assertion failed");
`else
`define CLBP_ASSERT(lbl, clk, rst_n, expr)
`define CLBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/clbp_pkg.sv
// Types and fixed constants for the circular LBP code block.
// Depends on nothing; imported by every module of the block but clbp_line_buf.
`default_nettype none
package clbp_pkg;

    localparam int PIXEL_IN_W = 16;
    localparam int CODE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = 10;
    localparam int HGT_W      = 11;
    localparam int DIM_MIN    = 3;
    localparam int DIM_RESET  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Q16 bilinear weights; the centre weight is folded into the threshold.
    localparam int W_CORNER_SHIFT = 15;
    localparam int W_EDGE         = 13573;
    localparam int W_CENTRE_NET   = 65536 - 5622;

    typedef struct packed {
        logic emit;
        logic last;
    } t_item_ctl;

endpackage
`default_nettype wire

### rtl/core/clbp_line_buf.sv
// Line store RAM: one entry per column holding the two previous rows.
// One write port and one registered read port; no dependencies.
`default_nettype none
module clbp_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### rtl/core/clbp_window.sv
// 3x3 sliding window register with the valid flag of the centre it holds.
// Depends on clbp_pkg for the per-item control struct.
`default_nettype none
module clbp_window
    import clbp_pkg::*;
#(
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_shift,
    input  wire logic [PIXEL_BITS-1:0] i_top,
    input  wire logic [PIXEL_BITS-1:0] i_mid,
    input  wire logic [PIXEL_BITS-1:0] i_px,
    input  wire t_item_ctl             i_ctl,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic                       o_last,
    output logic      [PIXEL_BITS-1:0] o_win [9],
    input  wire logic                  i_ready
);

    logic [PIXEL_BITS-1:0] r_win [9];
    logic                  r_valid;
    logic                  r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_ctl.emit;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= i_top;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= i_mid;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= i_px;
            r_last   <= i_ctl.last;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_win   = r_win;

endmodule
`default_nettype wire

### rtl/core/clbp_code_out.sv
// Weighted diagonal sums, comparisons and the output register of the code.
// Depends on clbp_pkg for the Q16 weights and the code width.
`default_nettype none
module clbp_code_out
    import clbp_pkg::*;
#(
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_last,
    input  wire logic [PIXEL_BITS-1:0] i_win [9],
    output logic                       o_ready,
    output logic                       o_valid,
    output logic      [CODE_W-1:0]     o_code,
    output logic                       o_last,
    input  wire logic                  i_ready
);

    localparam int SUM_W = PIXEL_BITS + 16;

    function automatic logic [SUM_W-1:0] diag_lhs(
        input logic [PIXEL_BITS-1:0] corner,
        input logic [PIXEL_BITS-1:0] ea,
        input logic [PIXEL_BITS-1:0] eb
    );
        logic [PIXEL_BITS:0] edge_sum;
        edge_sum = {1'b0, ea} + {1'b0, eb};
        return (SUM_W'(corner) << W_CORNER_SHIFT) + SUM_W'(edge_sum) * SUM_W'(W_EDGE);
    endfunction

    logic [SUM_W-1:0] r_lhs [4];
    logic [SUM_W-1:0] r_rhs;
    logic [3:0]       r_axis;
    logic             r_p_last;
    logic             r_p_valid;
    logic             r_o_valid;
    logic [CODE_W-1:0] r_o_code;
    logic             r_o_last;
    logic             out_free;
    logic             p_ready;
    logic [CODE_W-1:0] n_code;

    assign out_free = !r_o_valid || i_ready;
    assign p_ready  = !r_p_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_ready) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_ready && i_valid) begin
            r_lhs[0] <= diag_lhs(i_win[8], i_win[7], i_win[5]);
            r_lhs[1] <= diag_lhs(i_win[2], i_win[1], i_win[5]);
            r_lhs[2] <= diag_lhs(i_win[0], i_win[1], i_win[3]);
            r_lhs[3] <= diag_lhs(i_win[6], i_win[7], i_win[3]);
            r_rhs    <= SUM_W'(i_win[4]) * SUM_W'(W_CENTRE_NET);
            r_axis   <= {i_win[7] > i_win[4], i_win[3] > i_win[4],
                         i_win[1] > i_win[4], i_win[5] > i_win[4]};
            r_p_last <= i_last;
        end
    end

    assign n_code = {r_axis[3], r_lhs[3] > r_rhs, r_axis[2], r_lhs[2] > r_rhs,
                     r_axis[1], r_lhs[1] > r_rhs, r_axis[0], r_lhs[0] > r_rhs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_p_valid) begin
            r_o_code <= n_code;
            r_o_last <= r_p_last;
        end
    end

    assign o_ready = p_ready;
    assign o_valid = r_o_valid;
    assign o_code  = r_o_code;
    assign o_last  = r_o_last;

endmodule
`default_nettype wire

### rtl/core/circular_lbp_code.sv
// Top level of the circular LBP (radius 1, 8 neighbours) code generator.
// Depends on clbp_pkg, clbp_line_buf, clbp_window, clbp_code_out and the assert header.
//
//   Channel   Direction  Handshake               Payload
//   s stream  in         i_s_tvalid/o_s_tready   i_s_tdata[15:0] pixel_value
//   m stream  out        o_m_tvalid/i_m_tready   o_m_tdata[7:0] lbp_code, o_m_tlast frame_end
//   cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index (0 width, 1 height), i_cfg_data
//
// One pixel is taken per clock while the m side does not stall; a code leaves after its below-right
// pixel is taken and passes the line store read, window, sums and output registers in turn.
// The line store reads one column and writes another in the same cycle, so a pixel fits each cycle.
// Reset sets both dimensions to 64 and the counters to zero; the line store is not cleared.
// A stall on the m side fills the pipeline stages and then drops o_s_tready.
`default_nettype none
`include "circular_lbp_code_assert.svh"
module circular_lbp_code
    import clbp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [PIXEL_IN_W-1:0] i_s_tdata,   // [15:0] pixel_value
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [CODE_W-1:0]     o_m_tdata,   // [7:0] lbp_code
    output logic                       o_m_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W       = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_RESET = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;

    logic [WID_W-1:0]      r_width;
    logic [HGT_W-1:0]      r_height;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [COL_W-1:0]      r_s1_col;
    t_item_ctl             r_s1_ctl;

    logic                  accept;
    logic                  cfg_wr;
    logic                  s1_adv;
    logic                  win_ready;
    logic [WID_W-1:0]      col_next;
    logic [HGT_W-1:0]      row_next;
    logic [WID_W-1:0]      n_width;
    logic [HGT_W-1:0]      n_height;
    logic [PIXEL_BITS-1:0] px;
    logic [2*PIXEL_BITS-1:0] rd_data;
    t_item_ctl             n_ctl;
    logic                  win_valid;
    logic                  win_last;
    logic [PIXEL_BITS-1:0] win [9];
    logic                  code_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && (i_cfg_index == REG_IMAGE_WIDTH ||
                                         i_cfg_index == REG_IMAGE_HEIGHT);
    assign o_s_tready  = !r_s1_valid || win_ready;
    assign accept      = i_s_tvalid && o_s_tready;
    assign s1_adv      = r_s1_valid && win_ready;
    assign px          = PIXEL_BITS'(i_s_tdata);

    assign col_next = WID_W'(r_col) + WID_W'(1);
    assign row_next = HGT_W'(r_row) + HGT_W'(1);

    assign n_width  = (i_cfg_data < CFG_DATA_W'(DIM_MIN)) ? WID_W'(DIM_MIN) :
                      (32'(i_cfg_data) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) :
                      WID_W'(i_cfg_data);
    assign n_height = (i_cfg_data < CFG_DATA_W'(DIM_MIN)) ? HGT_W'(DIM_MIN) :
                      (32'(i_cfg_data) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT) :
                      HGT_W'(i_cfg_data);

    assign n_ctl.emit = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
    assign n_ctl.last = (col_next == r_width) && (row_next == r_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(WIDTH_RESET);
            r_height <= HGT_W'(DIM_RESET);
            r_col    <= '0;
            r_row    <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_width <= n_width;
            end else begin
                r_height <= n_height;
            end
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_next >= r_width) begin
                r_col <= '0;
                r_row <= (row_next >= r_height) ? '0 : ROW_W'(row_next);
            end else begin
                r_col <= COL_W'(col_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px  <= px;
            r_s1_col <= r_col;
            r_s1_ctl <= n_ctl;
        end
    end

    clbp_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIXEL_BITS)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({rd_data[PIXEL_BITS-1:0], r_s1_px}),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data)
    );

    clbp_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_adv),
        .i_top   (rd_data[2*PIXEL_BITS-1:PIXEL_BITS]),
        .i_mid   (rd_data[PIXEL_BITS-1:0]),
        .i_px    (r_s1_px),
        .i_ctl   (r_s1_ctl),
        .o_ready (win_ready),
        .o_valid (win_valid),
        .o_last  (win_last),
        .o_win   (win),
        .i_ready (code_ready)
    );

    clbp_code_out #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_code_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (win_valid),
        .i_last  (win_last),
        .i_win   (win),
        .o_ready (code_ready),
        .o_valid (o_m_tvalid),
        .o_code  (o_m_tdata),
        .o_last  (o_m_tlast),
        .i_ready (i_m_tready)
    );

    `CLBP_ASSERT(a_col_in_range, i_clk, i_rst_n, WID_W'(r_col) < r_width)
    `CLBP_ASSERT(a_row_in_range, i_clk, i_rst_n, HGT_W'(r_row) < r_height)
    `CLBP_ASSERT(a_ram_no_collide, i_clk, i_rst_n, !(s1_adv && accept) || (r_s1_col != r_col))
    `CLBP_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, cfg_wr, r_col == '0 && r_row == '0)

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for circular_lbp_code: streams pixel images through the block
// and checks every 8-bit LBP code and its frame_end flag against an in-bench predictor.
// Depends on clbp_pkg and the circular_lbp_code RTL; needs no files or arguments.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clbp_pkg::*;

    localparam int MAX_COLS       = 1024;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int WIDE_COLS      = 40;

    localparam logic [35:0] Q16_CORNER = 36'd32768;
    localparam logic [35:0] Q16_EDGE   = 36'd13573;
    localparam logic [35:0] Q16_CENTRE = 36'd5622;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        GAPS_SEND_LIGHT,
        GAPS_SEND_HEAVY,
        GAPS_NONE
    } t_gap_mode;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              frame_end;
    } t_lbp_result;

    logic                  i_clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [PIXEL_IN_W-1:0] s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  s_tready;
    logic                  m_tvalid;
    logic [CODE_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  cfg_ready;

    t_gap_mode             gap_mode      = GAPS_SEND_LIGHT;
    logic [PIXEL_IN_W-1:0] pixel_base    = '0;
    logic [PIXEL_IN_W-1:0] pixel_q [$];
    t_lbp_result           codes_due [$];
    int unsigned           fail_count    = 0;
    int unsigned           hold_requests = 0;
    int unsigned           holds_done    = 0;
    int unsigned           hold_left     = 0;
    int unsigned           quiet_cycles  = 0;

    // Predictor state: two previous rows, the 3x3 window and the raster position.
    logic [PIXEL_IN_W-1:0] upper_row [MAX_COLS];
    logic [PIXEL_IN_W-1:0] middle_row [MAX_COLS];
    logic [PIXEL_IN_W-1:0] win [9];
    int unsigned           img_w   = DIM_RESET;
    int unsigned           img_h   = DIM_RESET;
    int unsigned           col_idx = 0;
    int unsigned           row_idx = 0;

    circular_lbp_code #(
        .MAX_WIDTH (MAX_COLS),
        .PIXEL_BITS(PIXEL_IN_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic diag_exceeds(input logic [PIXEL_IN_W-1:0] corner,
                                          input logic [PIXEL_IN_W-1:0] edge_a,
                                          input logic [PIXEL_IN_W-1:0] edge_b,
                                          input logic [PIXEL_IN_W-1:0] centre);
        logic [35:0] k, a, b, m, sample;
        k = 36'(corner);
        a = 36'(edge_a);
        b = 36'(edge_b);
        m = 36'(centre);
        sample = k * Q16_CORNER + a * Q16_EDGE + b * Q16_EDGE + m * Q16_CENTRE;
        return sample > (m << 16);
    endfunction

    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                              input int unsigned hi);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic logic [PIXEL_IN_W-1:0] random_pixel(input logic [PIXEL_IN_W-1:0] base);
        case ($urandom_range(0, 9)) inside
            0: return '0;
            1: return '1;
            [2:4]: return PIXEL_IN_W'($urandom_range(0, 65535));
            [5:7]: return base + PIXEL_IN_W'($urandom_range(0, 3));
            default: return base;
        endcase
    endfunction

    task automatic take_pixel(input logic [PIXEL_IN_W-1:0] px);
        logic [PIXEL_IN_W-1:0] top, mid, c;
        t_lbp_result r;
        top = upper_row[col_idx];
        mid = middle_row[col_idx];
        win[0] = win[1]; win[1] = win[2]; win[2] = top;
        win[3] = win[4]; win[4] = win[5]; win[5] = mid;
        win[6] = win[7]; win[7] = win[8]; win[8] = px;
        upper_row[col_idx]  = mid;
        middle_row[col_idx] = px;
        if (col_idx >= 2 && row_idx >= 2) begin
            c = win[4];
            r.code = {win[7] > c, diag_exceeds(win[6], win[7], win[3], c),
                      win[3] > c, diag_exceeds(win[0], win[1], win[3], c),
                      win[1] > c, diag_exceeds(win[2], win[1], win[5], c),
                      win[5] > c, diag_exceeds(win[8], win[7], win[5], c)};
            r.frame_end = (col_idx + 1 == img_w) && (row_idx + 1 == img_h);
            codes_due.push_back(r);
        end
        col_idx++;
        if (col_idx >= img_w) begin
            col_idx = 0;
            row_idx++;
            if (row_idx >= img_h) row_idx = 0;
        end
    endtask

    task automatic check_code(input logic [CODE_W-1:0] code, input logic frame_end);
        t_lbp_result want;
        if (codes_due.size() == 0) begin
            $error("unexpected transaction: lbp_code %02h frame_end %0b", code, frame_end);
            fail_count++;
        end else begin
            want = codes_due.pop_front();
            if (code !== want.code) begin
                $error("lbp_code: expected %02h, got %02h", want.code, code);
                fail_count++;
            end
            if (frame_end !== want.frame_end) begin
                $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
                fail_count++;
            end
        end
    endtask

    // Pixel source.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) take_pixel(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 &&
                    !(gap_mode == GAPS_SEND_LIGHT && $urandom_range(0, 99) < 21) &&
                    !(gap_mode == GAPS_SEND_HEAVY && $urandom_range(0, 99) < 51)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Code sink.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_code(m_tdata, m_tlast);
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (holds_done != hold_requests && m_tvalid) begin
                hold_left  <= LONG_HOLD;
                holds_done <= holds_done + 1;
                m_tready   <= 1'b0;
            end else if (gap_mode == GAPS_SEND_LIGHT) begin
                m_tready <= $urandom_range(0, 99) >= 51;
            end else if (gap_mode == GAPS_SEND_HEAVY) begin
                m_tready <= $urandom_range(0, 99) >= 21;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: begin
                img_w   = clamp_dim(data, MAX_COLS);
                col_idx = 0;
                row_idx = 0;
            end
            REG_IMAGE_HEIGHT: begin
                img_h   = clamp_dim(data, MAX_HEIGHT);
                col_idx = 0;
                row_idx = 0;
            end
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (pixel_q.size() != 0 || s_tvalid || codes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(input int unsigned count);
        repeat (count) pixel_q.push_back(random_pixel(pixel_base));
    endtask

    task automatic random_phase();
        int unsigned w, h;
        logic [CFG_DATA_W-1:0] wdata;
        w = $urandom_range(3, 24);
        h = $urandom_range(3, 10);
        wdata = CFG_DATA_W'(w);
        if ($urandom_range(0, 5) == 0) begin
            w = DIM_MIN;
            wdata = CFG_DATA_W'($urandom_range(0, 2));
        end
        pixel_base = PIXEL_IN_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                      CFG_DATA_W'($urandom_range(0, 2047)));
        end
        if ($urandom_range(0, 1)) begin
            write_reg(REG_IMAGE_WIDTH, wdata);
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        end else begin
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            write_reg(REG_IMAGE_WIDTH, wdata);
        end
        queue_random(w * h * $urandom_range(1, 2) + $urandom_range(0, w - 1));
        wait_idle();
    endtask

    initial begin
        logic [PIXEL_IN_W-1:0] frame_a [24];
        logic [PIXEL_IN_W-1:0] frame_tail [6];
        // A 3x5 image with a dark hole, a bright ridge and small steps, then a flat
        // start of the next image where every comparison is an exact tie.
        frame_a = '{16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'h0000, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h0007, 16'h0007, 16'h0007,
                    16'h0007, 16'h0008, 16'h0006,
                    16'h1234, 16'h1234, 16'h1234,
                    16'h1234, 16'h1234, 16'h1234,
                    16'h1234, 16'h1234, 16'h1234};
        frame_tail = '{16'h0000, 16'h1234, 16'h1235, 16'h0001, 16'h0002, 16'h0003};

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        gap_mode   = GAPS_SEND_LIGHT;
        pixel_base = PIXEL_IN_W'($urandom_range(0, 65535));
        queue_random(198);
        wait_idle();

        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, 11'd5);
        foreach (frame_a[i]) pixel_q.push_back(frame_a[i]);
        wait_idle();
        // Writes to unused indexes must leave the raster position alone.
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '0);
        foreach (frame_tail[i]) pixel_q.push_back(frame_tail[i]);
        wait_idle();
        repeat (3) random_phase();

        gap_mode = GAPS_SEND_HEAVY;
        write_reg(REG_IMAGE_HEIGHT, 11'd2);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(WIDE_COLS));
        pixel_base = PIXEL_IN_W'($urandom_range(0, 65535));
        queue_random(3 * WIDE_COLS);
        wait_idle();
        repeat (3) random_phase();

        gap_mode = GAPS_NONE;
        hold_requests++;
        write_reg(REG_IMAGE_WIDTH, 11'd3);
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_HEIGHT));
        pixel_base = PIXEL_IN_W'($urandom_range(0, 65535));
        queue_random(150);
        wait_idle();
        repeat (2) random_phase();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
